[hw/rtl/nccs_pkg.sv]
// ----------------------------------------------------------------------------
// nccs_pkg
// Shared types and constants of the nand command cycle sequencer
// ----------------------------------------------------------------------------
package nccs_pkg;

  localparam int IN_W  = 48;
  localparam int OUT_W = 16;

  // nand command bytes
  localparam logic [7:0] OPC_READ0   = 8'h00;
  localparam logic [7:0] OPC_RDSPARE = 8'h50;
  localparam logic [7:0] OPC_SERIAL  = 8'h80;
  localparam logic [7:0] OPC_PROGRAM = 8'h10;
  localparam logic [7:0] OPC_READID  = 8'h90;
  localparam logic [7:0] OPC_ERASE1  = 8'h60;
  localparam logic [7:0] OPC_ERASE2  = 8'hD0;
  localparam logic [7:0] OPC_STATUS  = 8'h70;
  localparam logic [7:0] OPC_RDSTART = 8'h30;

  // operation kinds
  localparam logic [1:0] KIND_CMD  = 2'd0;
  localparam logic [1:0] KIND_ADDR = 2'd1;
  localparam logic [1:0] KIND_DOUT = 2'd2;
  localparam logic [1:0] KIND_DIN  = 2'd3;

  // cycle value sources
  localparam logic [2:0] VSEL_CONST = 3'd0;
  localparam logic [2:0] VSEL_ROW0  = 3'd1;
  localparam logic [2:0] VSEL_ROW1  = 3'd2;
  localparam logic [2:0] VSEL_ROW2  = 3'd3;
  localparam logic [2:0] VSEL_CNT   = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_LARGE_PAGE = 2'd0;
  localparam logic [1:0] CFG_DEV_SIZE   = 2'd1;
  localparam logic [1:0] CFG_FOUR_BUF   = 2'd2;

  localparam logic [5:0] DEV_SIZE_RESET = 6'd28;
  localparam logic [5:0] EXTRA_ROW_LP   = 6'd28;
  localparam logic [5:0] EXTRA_ROW_SP   = 6'd26;

  typedef struct packed {
    logic       load;
    logic       emit;
    logic [1:0] kind;
    logic       ext;
    logic [2:0] val_sel;
    logic [7:0] val_const;
    logic       wait_int;
    logic       last;
    logic       cnt_inc;
    logic       cnt_clr;
  } ctl_cmd_t;

  typedef struct packed {
    logic [7:0] opcode;
    logic       col_ok;
    logic       page_ok;
    logic       spare;
    logic       big_page;
    logic       extra_row;
    logic       xfer_last;
    logic       out_free;
  } dp_status_t;

endpackage

[hw/rtl/nccs_datapath.sv]
// ----------------------------------------------------------------------------
// nccs_datapath
// Request and configuration registers, buffer counter and output register
// ----------------------------------------------------------------------------
module nccs_datapath #(
  parameter int ROW_BITS = 24
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [nccs_pkg::IN_W-1:0] s_tdata,
  input  logic                    cfg_valid,
  input  logic [1:0]              cfg_index,
  input  logic [5:0]              cfg_data,
  input  nccs_pkg::ctl_cmd_t      cmd,
  output nccs_pkg::dp_status_t    st,
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [nccs_pkg::OUT_W-1:0] m_tdata,
  output logic                    m_tuser,
  output logic                    m_tlast
);
  import nccs_pkg::*;

  logic                large_page;
  logic [5:0]          dev_size_log2;
  logic                four_buf;
  logic [7:0]          opcode;
  logic                col_ok;
  logic [11:0]         col;
  logic                page_ok;
  logic [ROW_BITS-1:0] page;
  logic [1:0]          cnt;
  logic [23:0]         page_ext;
  logic [7:0]          value;

  always_ff @(posedge clk) begin
    if (rst) begin
      large_page    <= 1'b0;
      dev_size_log2 <= DEV_SIZE_RESET;
      four_buf      <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_LARGE_PAGE: large_page    <= cfg_data[0];
        CFG_DEV_SIZE:   dev_size_log2 <= cfg_data;
        CFG_FOUR_BUF:   four_buf      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      opcode  <= s_tdata[7:0];
      col_ok  <= s_tdata[8];
      col     <= s_tdata[20:9];
      page_ok <= s_tdata[21];
      page    <= s_tdata[22 +: ROW_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (cmd.load || cmd.cnt_clr) begin
      cnt <= 2'd0;
    end else if (cmd.cnt_inc) begin
      cnt <= cnt + 2'd1;
    end
  end

  assign page_ext = 24'(page);

  always_comb begin
    unique case (cmd.val_sel)
      VSEL_ROW0: value = page_ext[7:0];
      VSEL_ROW1: value = page_ext[15:8];
      VSEL_ROW2: value = page_ext[23:16];
      VSEL_CNT:  value = {6'd0, cnt};
      default:   value = cmd.val_const;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= {5'd0, cmd.wait_int, value, cmd.kind};
      m_tuser <= cmd.ext;
      m_tlast <= cmd.last;
    end
  end

  assign st.opcode    = opcode;
  assign st.col_ok    = col_ok;
  assign st.page_ok   = page_ok;
  assign st.spare     = !col_ok || (large_page ? col[11] : (|col[11:9]));
  assign st.big_page  = large_page;
  assign st.extra_row = large_page ? (dev_size_log2 >= EXTRA_ROW_LP)
                                   : (dev_size_log2 >= EXTRA_ROW_SP);
  assign st.xfer_last = (cnt == ((large_page && four_buf) ? 2'd3 : 2'd0));
  assign st.out_free  = !m_tvalid || m_tready;

endmodule

[hw/rtl/nccs_controller.sv]
// ----------------------------------------------------------------------------
// nccs_controller
// Sequencing state machine for command, address and buffer operations
// ----------------------------------------------------------------------------
module nccs_controller (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  nccs_pkg::dp_status_t st,
  output nccs_pkg::ctl_cmd_t   cmd
);
  import nccs_pkg::*;

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_DECODE  = 4'd1;
  localparam logic [3:0] ST_PRE     = 4'd2;
  localparam logic [3:0] ST_RDCMD   = 4'd3;
  localparam logic [3:0] ST_MAINCMD = 4'd4;
  localparam logic [3:0] ST_XIN     = 4'd5;
  localparam logic [3:0] ST_COL0    = 4'd6;
  localparam logic [3:0] ST_COL1    = 4'd7;
  localparam logic [3:0] ST_ROW0    = 4'd8;
  localparam logic [3:0] ST_ROW1    = 4'd9;
  localparam logic [3:0] ST_ROW2    = 4'd10;
  localparam logic [3:0] ST_RDSTART = 4'd11;
  localparam logic [3:0] ST_XOUT    = 4'd12;
  localparam logic [3:0] ST_RDID    = 4'd13;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       rd_phase;
  logic       rd_phase_next;

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    logic       col_eff;
    logic       is_emit;
    logic       rd_clear;
    logic [3:0] nxt;
    logic [3:0] post_addr;
    logic [3:0] entry;
    logic [3:0] after_col;
    logic [3:0] after_read;

    cmd           = '0;
    state_next    = state;
    rd_phase_next = rd_phase;
    is_emit       = 1'b0;
    rd_clear      = 1'b0;
    nxt           = ST_IDLE;

    col_eff    = st.col_ok || (rd_phase && (st.opcode == OPC_SERIAL));
    post_addr  = rd_phase ? (st.big_page ? ST_RDSTART : ST_XOUT)
                          : ((st.opcode == OPC_READID) ? ST_RDID : ST_IDLE);
    after_col  = st.page_ok ? ST_ROW0 : post_addr;
    entry      = col_eff ? ST_COL0 : after_col;
    after_read = (st.opcode == OPC_SERIAL) ? ST_MAINCMD : ST_IDLE;

    unique case (state)
      ST_IDLE: begin
        cmd.load = s_tvalid;
        if (s_tvalid) begin
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        rd_phase_next = 1'b0;
        unique case (st.opcode)
          OPC_STATUS, OPC_ERASE1, OPC_ERASE2, OPC_READID: state_next = ST_MAINCMD;
          OPC_READ0, OPC_RDSPARE: begin
            state_next    = ST_RDCMD;
            rd_phase_next = 1'b1;
          end
          OPC_SERIAL: begin
            if (st.spare && st.big_page) begin
              state_next    = ST_RDCMD;
              rd_phase_next = 1'b1;
            end else if (st.spare || !st.big_page) begin
              state_next = ST_PRE;
            end else begin
              state_next = ST_MAINCMD;
            end
          end
          OPC_PROGRAM: state_next = ST_XIN;
          default:     state_next = ST_IDLE;
        endcase
      end
      ST_PRE: begin
        is_emit       = 1'b1;
        cmd.val_const = st.spare ? OPC_RDSPARE : OPC_READ0;
        nxt           = ST_MAINCMD;
      end
      ST_RDCMD: begin
        is_emit       = 1'b1;
        cmd.val_const = st.big_page ? OPC_READ0 : st.opcode;
        nxt           = entry;
      end
      ST_MAINCMD: begin
        is_emit       = 1'b1;
        cmd.val_const = st.opcode;
        cmd.wait_int  = (st.opcode == OPC_STATUS) || (st.opcode == OPC_PROGRAM) ||
                        (st.opcode == OPC_READID);
        nxt           = entry;
      end
      ST_XIN: begin
        is_emit      = 1'b1;
        cmd.kind     = KIND_DIN;
        cmd.val_sel  = VSEL_CNT;
        cmd.wait_int = 1'b1;
        nxt          = st.xfer_last ? ST_MAINCMD : ST_XIN;
      end
      ST_COL0: begin
        is_emit      = 1'b1;
        cmd.kind     = KIND_ADDR;
        cmd.wait_int = !st.page_ok;
        nxt          = st.big_page ? ST_COL1 : after_col;
      end
      ST_COL1: begin
        is_emit  = 1'b1;
        cmd.kind = KIND_ADDR;
        nxt      = after_col;
      end
      ST_ROW0: begin
        is_emit     = 1'b1;
        cmd.kind    = KIND_ADDR;
        cmd.val_sel = VSEL_ROW0;
        nxt         = ST_ROW1;
      end
      ST_ROW1: begin
        is_emit      = 1'b1;
        cmd.kind     = KIND_ADDR;
        cmd.val_sel  = VSEL_ROW1;
        cmd.wait_int = !st.extra_row;
        nxt          = st.extra_row ? ST_ROW2 : post_addr;
      end
      ST_ROW2: begin
        is_emit      = 1'b1;
        cmd.kind     = KIND_ADDR;
        cmd.val_sel  = VSEL_ROW2;
        cmd.wait_int = 1'b1;
        nxt          = post_addr;
      end
      ST_RDSTART: begin
        is_emit       = 1'b1;
        cmd.val_const = OPC_RDSTART;
        cmd.wait_int  = 1'b1;
        nxt           = ST_XOUT;
      end
      ST_XOUT: begin
        is_emit      = 1'b1;
        cmd.kind     = KIND_DOUT;
        cmd.val_sel  = VSEL_CNT;
        cmd.wait_int = 1'b1;
        rd_clear     = st.xfer_last;
        nxt          = st.xfer_last ? after_read : ST_XOUT;
      end
      ST_RDID: begin
        is_emit      = 1'b1;
        cmd.ext      = 1'b1;
        cmd.wait_int = 1'b1;
        nxt          = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase

    if (is_emit && st.out_free) begin
      cmd.emit   = 1'b1;
      cmd.last   = (nxt == ST_IDLE);
      state_next = nxt;
      if (state == ST_XIN || state == ST_XOUT) begin
        cmd.cnt_inc = !st.xfer_last;
        cmd.cnt_clr = st.xfer_last;
      end
      if (rd_clear) begin
        rd_phase_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      rd_phase <= 1'b0;
    end else begin
      state    <= state_next;
      rd_phase <= rd_phase_next;
    end
  end

`ifndef SYNTHESIS
  a_accept_decode: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state == ST_DECODE)
    else $error("accepted item not followed by decode");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> st.out_free)
    else $error("operation issued into a full output register");

  a_read_path: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RDSTART || state == ST_XOUT) |-> rd_phase)
    else $error("read start or data out outside a read sequence");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.emit && cmd.last |=> state == ST_IDLE)
    else $error("sequencer busy after final operation");
`endif

endmodule

[hw/rtl/nand_command_cycle_sequencer_core.sv]
// ----------------------------------------------------------------------------
// nand_command_cycle_sequencer_core
// Turns one nand request into its run of controller operations
// ----------------------------------------------------------------------------
// One request is taken when the sequencer is idle; the cycle after that is
// spent decoding it, and then the state machine issues one operation per
// clock into the output register while the result side does not stall, so a
// request produces n operations (n from 0 to 17). An unknown command byte is
// consumed with no output.
// Configuration writes are taken at any time but are meant for idle periods.
module nand_command_cycle_sequencer_core #(
  parameter int ROW_BITS = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // opcode[7:0], column_present[8], column_addr[20:9], page_present[21],
  // row_address[45:22], zero pad[47:46]
  input  logic [47:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // op_kind[1:0], cycle_value[9:2], wait_interrupt[10], zero pad[15:11]
  output logic [15:0] m_tdata,
  // op_kind_ext[0]
  output logic        m_tuser,
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [5:0]  cfg_data
);
  import nccs_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t st;

  assign cfg_ready = 1'b1;

  nccs_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  nccs_datapath #(
    .ROW_BITS (ROW_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .st        (st),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule
